// File: rtl/core/rfds_pkg.sv
`timescale 1ns / 1ps

package rfds_pkg;

    localparam int MAX_RES        = 32;
    localparam int DEPTH_DEF      = 32;
    localparam int CELL_SHIFT_DEF = 16;

    localparam int CELL_W  = 12;
    localparam int CTR_W   = 16;
    localparam int RAD_W   = 8;
    localparam int RSQ_W   = 16;
    localparam int DIFF_W  = 17;
    localparam int SQ_W    = 33;
    localparam int DIST_W  = 34;
    localparam int DOUT_W  = 26;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    localparam logic [DOUT_W-1:0] DIST_SAT = {DOUT_W{1'b1}};

    // register indexes, taken from paddr[3:2]
    localparam logic [1:0] REG_CENTER_X    = 2'd0;
    localparam logic [1:0] REG_CENTER_Z    = 2'd1;
    localparam logic [1:0] REG_KEEP_RADIUS = 2'd2;

    localparam logic [RAD_W-1:0] RADIUS_RST = 8'd8;

    typedef struct packed {
        logic signed [CELL_W-1:0] cell_x;
        logic signed [CELL_W-1:0] cell_z;
        logic                     final_entry;
    } t_in_word;

    typedef struct packed {
        logic signed [CELL_W-1:0] out_x;
        logic signed [CELL_W-1:0] out_z;
        logic [DOUT_W-1:0]        dist_sq;
        logic                     empty_batch;
        logic                     overflowed;
        logic                     end_of_run;
    } t_out_word;

    typedef struct packed {
        logic signed [CELL_W-1:0] x;
        logic signed [CELL_W-1:0] z;
    } t_cell;

    typedef struct packed {
        logic  valid;
        logic  last;
        t_cell pos;
    } t_probe;

    typedef struct packed {
        logic              valid;
        logic              last;
        t_cell             pos;
        logic [DIST_W-1:0] d;
    } t_dist;

endpackage

// File: rtl/core/rfds_store.sv
`timescale 1ns / 1ps

module rfds_store #(
    parameter int CAP = rfds_pkg::MAX_RES,
    parameter int IW  = $clog2(CAP)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_we,
    input  logic [IW-1:0]         i_waddr,
    input  rfds_pkg::t_cell       i_wdata,
    input  logic                  i_rd_en,
    input  logic                  i_rd_last,
    input  logic [IW-1:0]         i_raddr,
    output rfds_pkg::t_probe      o_probe,
    output logic [IW-1:0]         o_ridx
);
    import rfds_pkg::*;

    t_cell          r_mem [CAP];
    t_cell          r_rdata;
    logic           r_rvalid;
    logic           r_rlast;
    logic [IW-1:0]  r_ridx;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_rd_en) begin
            r_rdata <= r_mem[i_raddr];
            r_ridx  <= i_raddr;
            r_rlast <= i_rd_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rvalid <= 1'b0;
        end else begin
            r_rvalid <= i_rd_en;
        end
    end

    assign o_probe.valid = r_rvalid;
    assign o_probe.last  = r_rlast;
    assign o_probe.pos   = r_rdata;
    assign o_ridx        = r_ridx;

endmodule

// File: rtl/core/rfds_div.sv
`timescale 1ns / 1ps

module rfds_div #(
    parameter int CELL_SHIFT = rfds_pkg::CELL_SHIFT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [rfds_pkg::CTR_W-1:0]   i_center_x,
    input  logic signed [rfds_pkg::CTR_W-1:0]   i_center_z,
    output logic                                o_done,
    output logic signed [rfds_pkg::CTR_W-1:0]   o_cx,
    output logic signed [rfds_pkg::CTR_W-1:0]   o_cz
);
    import rfds_pkg::*;

    // floor(m / CELL_SHIFT) == (m * RECIP) >> SH_S for every 16-bit magnitude m
    localparam int SH_S   = CTR_W + $clog2(CELL_SHIFT);
    localparam int RCP_W  = CTR_W + 2;
    localparam int PROD_W = CTR_W + RCP_W;
    localparam logic [RCP_W-1:0] RECIP =
        RCP_W'(((longint'(1) << SH_S) + longint'(CELL_SHIFT) - 1) / longint'(CELL_SHIFT));

    logic                    r_busy, r_done;
    logic                    r_negx, r_negz;
    logic [CTR_W-1:0]        r_magx, r_magz;
    logic signed [CTR_W-1:0] r_cx, r_cz;
    logic [PROD_W-1:0]       px, pz;
    logic [CTR_W-1:0]        qx, qz;

    // magnitudes first, then one reciprocal multiply; sign restored after
    assign px = {{RCP_W{1'b0}}, r_magx} * {{CTR_W{1'b0}}, RECIP};
    assign pz = {{RCP_W{1'b0}}, r_magz} * {{CTR_W{1'b0}}, RECIP};
    assign qx = CTR_W'(px >> SH_S);
    assign qz = CTR_W'(pz >> SH_S);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= i_start;
            r_done <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_magx <= i_center_x[CTR_W-1] ? CTR_W'(-i_center_x) : CTR_W'(i_center_x);
            r_magz <= i_center_z[CTR_W-1] ? CTR_W'(-i_center_z) : CTR_W'(i_center_z);
            r_negx <= i_center_x[CTR_W-1];
            r_negz <= i_center_z[CTR_W-1];
        end
        if (r_busy) begin
            r_cx <= r_negx ? -$signed(qx) : $signed(qx);
            r_cz <= r_negz ? -$signed(qz) : $signed(qz);
        end
    end

    assign o_done = r_done;
    assign o_cx   = r_cx;
    assign o_cz   = r_cz;

endmodule

// File: rtl/core/rfds_dist.sv
`timescale 1ns / 1ps

module rfds_dist #(
    parameter int IW = 5
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic signed [rfds_pkg::CTR_W-1:0]  i_cx,
    input  logic signed [rfds_pkg::CTR_W-1:0]  i_cz,
    input  rfds_pkg::t_probe                   i_probe,
    input  logic [IW-1:0]                      i_idx,
    output rfds_pkg::t_dist                    o_dist,
    output logic [IW-1:0]                      o_idx
);
    import rfds_pkg::*;

    // three stages: differences, squares, sum
    logic                     r_v1, r_v2, r_v3;
    logic                     r_l1, r_l2, r_l3;
    t_cell                    r_c1, r_c2, r_c3;
    logic [IW-1:0]            r_i1, r_i2, r_i3;
    logic signed [DIFF_W-1:0] r_dx, r_dz;
    logic [SQ_W-1:0]          r_sx, r_sz;
    logic [DIST_W-1:0]        r_d;
    logic signed [2*DIFF_W-1:0] px, pz;

    assign px = r_dx * r_dx;
    assign pz = r_dz * r_dz;

    always_ff @(posedge i_clk) begin
        r_dx <= DIFF_W'(i_cx) - DIFF_W'(i_probe.pos.x);
        r_dz <= DIFF_W'(i_cz) - DIFF_W'(i_probe.pos.z);
        r_l1 <= i_probe.last;
        r_c1 <= i_probe.pos;
        r_i1 <= i_idx;
        r_sx <= px[SQ_W-1:0];
        r_sz <= pz[SQ_W-1:0];
        r_l2 <= r_l1;
        r_c2 <= r_c1;
        r_i2 <= r_i1;
        r_d  <= DIST_W'(r_sx) + DIST_W'(r_sz);
        r_l3 <= r_l2;
        r_c3 <= r_c2;
        r_i3 <= r_i2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_probe.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    assign o_dist.valid = r_v3;
    assign o_dist.last  = r_l3;
    assign o_dist.pos   = r_c3;
    assign o_dist.d     = r_d;
    assign o_idx        = r_i3;

endmodule

// File: rtl/core/radius_filter_distance_sort_top.sv
`timescale 1ns / 1ps

// channel   valid         stall         word
// --------  ------------  ------------  -----------------------------
// in        i_in_valid    o_in_stall    i_in_data   (t_in_word)
// out       o_out_valid   i_out_stall   o_out_data  (t_out_word)
// config    APB write/read at byte 4*index, pready tied high
//
// Non-final word: stored on acceptance while the store has room. Final word: center divide
// (reciprocal multiply), then one pass over the N stored entries per emitted
// word (at least one pass); passes are bounded by the single store read port.
// Reset (i_rst_n low, synchronous) clears counts, flags and config registers to
// their defaults; the entry store and the payload registers are not cleared.
// An output stall holds the result register; the scan waits behind it.

module radius_filter_distance_sort_top #(
    parameter int DEPTH      = rfds_pkg::DEPTH_DEF,
    parameter int CELL_SHIFT = rfds_pkg::CELL_SHIFT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  rfds_pkg::t_in_word            i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output rfds_pkg::t_out_word           o_out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rfds_pkg::ADDR_W-1:0]   paddr,
    input  logic [rfds_pkg::DATA_W-1:0]   pwdata,
    output logic [rfds_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import rfds_pkg::*;

    localparam int CAP = (DEPTH < MAX_RES) ? DEPTH : MAX_RES;
    localparam int IW  = $clog2(CAP);
    localparam int CW  = $clog2(CAP + 1);

    typedef enum logic [3:0] {
        ST_LOAD = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_EMIT = 4'b1000
    } t_state;

    // config registers
    logic signed [CTR_W-1:0] r_center_x, r_center_z;
    logic [RAD_W-1:0]        r_radius;
    logic                    cfg_wr;
    logic [1:0]              cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_z <= '0;
            r_radius   <= RADIUS_RST;
        end else if (cfg_wr && paddr[1:0] == 2'b00) begin
            case (cfg_idx)
                REG_CENTER_X:    r_center_x <= pwdata[CTR_W-1:0];
                REG_CENTER_Z:    r_center_z <= pwdata[CTR_W-1:0];
                REG_KEEP_RADIUS: r_radius   <= pwdata[RAD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_CENTER_X:    prdata = DATA_W'(r_center_x);
            REG_CENTER_Z:    prdata = DATA_W'(r_center_z);
            REG_KEEP_RADIUS: prdata = DATA_W'(r_radius);
            default:         prdata = '0;
        endcase
    end

    // control state
    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic              r_ovf, n_ovf;
    logic              r_first, n_first;
    logic [CW-1:0]     r_kept, n_kept;
    logic [CW-1:0]     r_emit_cnt, n_emit_cnt;
    logic              r_issuing, n_issuing;
    logic [IW-1:0]     r_rd_idx, n_rd_idx;
    logic              r_best_vld, n_best_vld;
    logic              r_out_valid, n_out_valid;

    // payload state
    logic [RSQ_W-1:0]  r_rsq;
    t_cell             r_best_cell, n_best_cell;
    logic [DIST_W-1:0] r_best_d, n_best_d;
    logic [IW-1:0]     r_best_idx, n_best_idx;
    logic [DIST_W-1:0] r_prev_d, n_prev_d;
    logic [IW-1:0]     r_prev_idx, n_prev_idx;
    t_out_word         r_out, n_out;

    logic              in_acc;
    logic              store_we;
    t_cell             wcell;
    logic              rd_en, rd_last;
    t_probe            probe;
    logic [IW-1:0]     probe_idx;
    logic              div_start, div_done;
    logic signed [CTR_W-1:0] cx, cz;
    t_dist             ds;
    logic [IW-1:0]     ds_idx;
    logic              keep, below, cand, better;
    logic              slot_free, emit_load, run_end;

    assign o_in_stall = (r_state != ST_LOAD);
    assign in_acc     = i_in_valid && (r_state == ST_LOAD);
    assign store_we   = in_acc && (r_count < CW'(CAP));
    assign wcell.x    = i_in_data.cell_x;
    assign wcell.z    = i_in_data.cell_z;
    assign div_start  = in_acc && i_in_data.final_entry;
    assign rd_en      = (r_state == ST_SCAN) && r_issuing;
    assign rd_last    = (CW'(r_rd_idx) + 1'b1) == r_count;

    rfds_store #(.CAP(CAP), .IW(IW)) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_we      (store_we),
        .i_waddr   (r_count[IW-1:0]),
        .i_wdata   (wcell),
        .i_rd_en   (rd_en),
        .i_rd_last (rd_last),
        .i_raddr   (r_rd_idx),
        .o_probe   (probe),
        .o_ridx    (probe_idx)
    );

    rfds_div #(.CELL_SHIFT(CELL_SHIFT)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_center_x (r_center_x),
        .i_center_z (r_center_z),
        .o_done     (div_done),
        .o_cx       (cx),
        .o_cz       (cz)
    );

    rfds_dist #(.IW(IW)) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cx    (cx),
        .i_cz    (cz),
        .i_probe (probe),
        .i_idx   (probe_idx),
        .o_dist  (ds),
        .o_idx   (ds_idx)
    );

    // next word is the largest (distance, earliest index) below the last one sent
    assign keep   = ds.valid && (ds.d <= DIST_W'(r_rsq));
    assign below  = r_first || (ds.d < r_prev_d) ||
                    ((ds.d == r_prev_d) && (ds_idx > r_prev_idx));
    assign cand   = keep && below;
    assign better = !r_best_vld || (ds.d > r_best_d);

    assign slot_free = !r_out_valid || !i_out_stall;
    assign emit_load = (r_state == ST_EMIT) && slot_free;
    assign run_end   = (r_kept == '0) || ((r_emit_cnt + 1'b1) == r_kept);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_first     = r_first;
        n_kept      = r_kept;
        n_emit_cnt  = r_emit_cnt;
        n_issuing   = r_issuing;
        n_rd_idx    = r_rd_idx;
        n_best_vld  = r_best_vld;
        n_best_cell = r_best_cell;
        n_best_d    = r_best_d;
        n_best_idx  = r_best_idx;
        n_prev_d    = r_prev_d;
        n_prev_idx  = r_prev_idx;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;

        case (r_state)
            ST_LOAD: begin
                if (in_acc) begin
                    if (store_we) begin
                        n_count = r_count + 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in_data.final_entry) begin
                        n_state = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state    = ST_SCAN;
                    n_issuing  = 1'b1;
                    n_rd_idx   = '0;
                    n_best_vld = 1'b0;
                    n_kept     = '0;
                    n_first    = 1'b1;
                end
            end
            ST_SCAN: begin
                if (rd_en) begin
                    n_rd_idx = r_rd_idx + 1'b1;
                    if (rd_last) begin
                        n_issuing = 1'b0;
                    end
                end
                if (r_first && keep) begin
                    n_kept = r_kept + 1'b1;
                end
                if (cand && better) begin
                    n_best_vld  = 1'b1;
                    n_best_cell = ds.pos;
                    n_best_d    = ds.d;
                    n_best_idx  = ds_idx;
                end
                if (ds.valid && ds.last) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (emit_load) begin
                    n_out_valid        = 1'b1;
                    n_out.overflowed   = r_ovf;
                    n_out.end_of_run   = run_end;
                    if (r_kept == '0) begin
                        n_out.out_x       = '0;
                        n_out.out_z       = '0;
                        n_out.dist_sq     = '0;
                        n_out.empty_batch = 1'b1;
                    end else begin
                        n_out.out_x       = r_best_cell.x;
                        n_out.out_z       = r_best_cell.z;
                        n_out.dist_sq     = (r_best_d > DIST_W'(DIST_SAT)) ? DIST_SAT
                                                                           : r_best_d[DOUT_W-1:0];
                        n_out.empty_batch = 1'b0;
                    end
                    if (run_end) begin
                        n_state    = ST_LOAD;
                        n_count    = '0;
                        n_ovf      = 1'b0;
                        n_emit_cnt = '0;
                        n_first    = 1'b1;
                    end else begin
                        n_state    = ST_SCAN;
                        n_emit_cnt = r_emit_cnt + 1'b1;
                        n_first    = 1'b0;
                        n_prev_d   = r_best_d;
                        n_prev_idx = r_best_idx;
                        n_best_vld = 1'b0;
                        n_issuing  = 1'b1;
                        n_rd_idx   = '0;
                    end
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_first     <= 1'b1;
            r_kept      <= '0;
            r_emit_cnt  <= '0;
            r_issuing   <= 1'b0;
            r_rd_idx    <= '0;
            r_best_vld  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_first     <= n_first;
            r_kept      <= n_kept;
            r_emit_cnt  <= n_emit_cnt;
            r_issuing   <= n_issuing;
            r_rd_idx    <= n_rd_idx;
            r_best_vld  <= n_best_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_best_cell <= n_best_cell;
        r_best_d    <= n_best_d;
        r_best_idx  <= n_best_idx;
        r_prev_d    <= n_prev_d;
        r_prev_idx  <= n_prev_idx;
        r_out       <= n_out;
        if (div_start) begin
            r_rsq <= RSQ_W'(r_radius * r_radius);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAP))
        else $error("entry count above capacity");

    a_emit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && r_kept != '0) |-> (r_emit_cnt < r_kept))
        else $error("more words emitted than entries kept");

    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.empty_batch) |-> o_out_data.end_of_run)
        else $error("empty batch word without end of run");

    a_batch_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && emit_load && run_end) |=>
            (r_count == '0 && !r_ovf && r_state == ST_LOAD))
        else $error("batch state not cleared after last word");

    a_scan_no_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> !store_we)
        else $error("store written during scan");

endmodule

// File: sim/radius_filter_distance_sort_top_tb.sv
`timescale 1ns / 1ps

module radius_filter_distance_sort_top_tb;
    import rfds_pkg::*;

    localparam int CAPACITY    = (DEPTH_DEF < MAX_RES) ? DEPTH_DEF : MAX_RES;
    localparam int CELL_DIV    = CELL_SHIFT_DEF;
    localparam int IDLE_LIMIT  = 20000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = 64;
    localparam int TAIL        = 200;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        out_stall = 1'b0;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [3:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    t_in_word    in_data   = '0;
    logic        in_stall;
    logic        out_valid;
    t_out_word   out_data;
    logic [31:0] prdata;
    logic        pready;

    // shadow of the block's registers and batch store
    shortint     ctr_x;
    shortint     ctr_z;
    byte unsigned ctr_radius;
    t_cell       batch_cells[$];
    bit          batch_overflow;
    t_out_word   expected_words[$];

    int errors;
    int items_sent;
    int words_checked;
    int batches;
    int overflow_batches;
    int empty_batches;
    int reg_writes;
    int burst_left;
    int idle_cycles;
    bit gaps_on = 1'b1;
    bit hold_req;
    bit hold_active;

    radius_filter_distance_sort_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------- prediction

    // store one accepted word; on the final word sort the batch, farthest first
    task automatic absorb_word(input t_in_word w);
        t_cell  run_cell [MAX_RES];
        longint run_dist [MAX_RES];
        t_cell  c;
        t_out_word o;
        int     kept, p, cx, cz, dx, dz;
        longint d, rsq;
        c.x = w.cell_x;
        c.z = w.cell_z;
        if (batch_cells.size() < CAPACITY) begin
            batch_cells = {batch_cells, c};
        end else begin
            batch_overflow = 1'b1;
        end
        if (!w.final_entry) return;

        cx   = int'(ctr_x) / CELL_DIV;   // truncates toward zero
        cz   = int'(ctr_z) / CELL_DIV;
        rsq  = longint'(ctr_radius) * ctr_radius;
        kept = 0;
        for (int i = 0; i < batch_cells.size(); i++) begin
            dx = cx - int'(batch_cells[i].x);
            dz = cz - int'(batch_cells[i].z);
            d  = longint'(dx) * dx + longint'(dz) * dz;
            if (d > rsq) continue;
            // strict compare keeps equal distances in arrival order
            p = kept;
            while (p > 0 && run_dist[p-1] < d) begin
                run_dist[p] = run_dist[p-1];
                run_cell[p] = run_cell[p-1];
                p--;
            end
            run_dist[p] = d;
            run_cell[p] = batch_cells[i];
            kept++;
        end

        if (kept == 0) begin
            o             = '0;
            o.empty_batch = 1'b1;
            o.overflowed  = batch_overflow;
            o.end_of_run  = 1'b1;
            expected_words = {expected_words, o};
            empty_batches++;
        end
        for (int i = 0; i < kept; i++) begin
            o             = '0;
            o.out_x       = run_cell[i].x;
            o.out_z       = run_cell[i].z;
            o.dist_sq     = (run_dist[i] > DIST_SAT) ? DIST_SAT : run_dist[i][DOUT_W-1:0];
            o.overflowed  = batch_overflow;
            o.end_of_run  = (i == kept - 1);
            expected_words = {expected_words, o};
        end
        batches++;
        if (batch_overflow) overflow_batches++;
        batch_cells.delete();
        batch_overflow = 1'b0;
    endtask

    // ---------------------------------------------------------------- checking

    function automatic void check_field(string name, longint want, longint got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge clk) begin
        t_out_word want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_words.size() == 0) begin
                errors++;
                $display("%0t: unexpected result word, expected none, got %h",
                         $time, out_data);
            end else begin
                want = expected_words.pop_front();
                check_field("out_x",       want.out_x,       out_data.out_x);
                check_field("out_z",       want.out_z,       out_data.out_z);
                check_field("dist_sq",     want.dist_sq,     out_data.dist_sq);
                check_field("empty_batch", want.empty_batch, out_data.empty_batch);
                check_field("overflowed",  want.overflowed,  out_data.overflowed);
                check_field("end_of_run",  want.end_of_run,  out_data.end_of_run);
                words_checked++;
            end
        end
    end

    // no progress on any port for too long ends the run
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)
                || (psel && penable && pready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no progress for %0d cycles, %0d words still expected",
                     $time, IDLE_LIMIT, expected_words.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ---------------------------------------------------------------- receiver

    initial begin
        int mode;
        int seg;
        @(posedge clk);
        forever begin
            if (hold_req) begin
                out_stall   <= 1'b1;
                hold_active = 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req    = 1'b0;
                hold_active = 1'b0;
            end else begin
                mode = $urandom_range(0, 3);
                seg  = $urandom_range(4, 32);
                repeat (seg) begin
                    case (mode)
                        0: out_stall <= 1'b0;
                        1: out_stall <= ($urandom_range(0, 3) == 0);
                        2: out_stall <= ($urandom_range(0, 9) < 6);
                        default: out_stall <= ~out_stall;
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    // ---------------------------------------------------------------- sender

    // valid stays high on return; the caller either sends again or drops it
    task automatic send_word(input t_in_word w);
        in_data  <= w;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        absorb_word(w);
        items_sent++;
    endtask

    task automatic pace();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 11);
        gap = gaps_on ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic int clamp_cell(int v);
        return (v < -2048) ? -2048 : ((v > 2047) ? 2047 : v);
    endfunction

    task automatic send_cell(input int x, input int z, input bit last);
        t_in_word w;
        w.cell_x      = x[CELL_W-1:0];
        w.cell_z      = z[CELL_W-1:0];
        w.final_entry = last;
        send_word(w);
        pace();
    endtask

    // near cells land around the current center cell, the rest anywhere
    task automatic send_batch(input int n, input int near_pct);
        int r, x, z, px, pz;
        r = int'(ctr_radius) + 2;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < near_pct) begin
                x = clamp_cell(int'(ctr_x) / CELL_DIV + int'($urandom_range(0, 2 * r)) - r);
                z = clamp_cell(int'(ctr_z) / CELL_DIV + int'($urandom_range(0, 2 * r)) - r);
            end else begin
                x = int'($urandom_range(0, 4095)) - 2048;
                z = int'($urandom_range(0, 4095)) - 2048;
            end
            // repeat a cell now and then to force equal distances
            if (i > 0 && $urandom_range(0, 7) == 0) begin
                x = px;
                z = pz;
            end
            send_cell(x, z, i == n - 1);
            px = x;
            pz = z;
        end
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // ---------------------------------------------------------------- registers

    task automatic apb_access(input bit wr, input logic [1:0] idx,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic reg_check(input logic [1:0] idx, input logic [31:0] want);
        logic [31:0] got;
        logic [31:0] mask;
        mask = (idx == REG_KEEP_RADIUS) ? 32'h0000_00FF : 32'h0000_FFFF;
        apb_access(1'b0, idx, '0, got);
        if ((got & mask) != (want & mask)) begin
            errors++;
            $display("%0t: register %0d read back, expected %h, got %h",
                     $time, idx, want & mask, got & mask);
        end
    endtask

    task automatic reg_set(input logic [1:0] idx, input int value);
        logic [31:0] unused;
        apb_access(1'b1, idx, value, unused);
        case (idx)
            REG_CENTER_X:    ctr_x      = value[15:0];
            REG_CENTER_Z:    ctr_z      = value[15:0];
            REG_KEEP_RADIUS: ctr_radius = value[7:0];
            default: ;
        endcase
        reg_writes++;
        reg_check(idx, value);
    endtask

    task automatic set_view(input int cx, input int cz, input int radius);
        reg_set(REG_CENTER_X, cx);
        reg_set(REG_CENTER_Z, cz);
        reg_set(REG_KEEP_RADIUS, radius);
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_reset_values();
        ctr_x      = 0;
        ctr_z      = 0;
        ctr_radius = RADIUS_RST;
        reg_check(REG_CENTER_X, 0);
        reg_check(REG_CENTER_Z, 0);
        reg_check(REG_KEEP_RADIUS, RADIUS_RST);
    endtask

    // reset view: boundary distance kept, one past it dropped, ties in order
    task automatic test_default_radius();
        send_cell(0, 0, 1'b0);
        send_cell(8, 0, 1'b0);
        send_cell(0, -8, 1'b0);
        send_cell(8, 1, 1'b0);
        send_cell(-2048, -2048, 1'b0);
        send_cell(2047, 2047, 1'b0);
        send_cell(5, 5, 1'b1);
        send_cell(100, 100, 1'b1);     // nothing kept
        wait_for_results();
    endtask

    task automatic test_center_extremes();
        set_view(32767, -32768, 255);
        send_cell(2047, -2048, 1'b0);
        send_cell(1792, -2048, 1'b0);
        send_cell(1791, -2048, 1'b0);
        send_cell(0, 0, 1'b0);
        send_cell(2047, -1793, 1'b1);
        wait_for_results();
        set_view(-32768, 32767, 0);
        send_cell(-2048, 2047, 1'b0);
        send_cell(-2047, 2047, 1'b0);
        send_cell(-2048, 2046, 1'b1);
        wait_for_results();
    endtask

    // -17/16 must give -1, not -2
    task automatic test_center_truncation();
        set_view(-17, -31, 0);
        send_cell(-1, -1, 1'b0);
        send_cell(-2, -2, 1'b0);
        send_cell(-1, -2, 1'b1);
        wait_for_results();
    endtask

    task automatic test_capacity();
        set_view(0, 0, 255);
        send_batch(CAPACITY + 4, 100);  // final word itself dropped
        send_batch(CAPACITY, 100);      // exactly full
        wait_for_results();
        reg_set(REG_KEEP_RADIUS, 0);
        send_batch(CAPACITY + 1, 0);
        wait_for_results();
    endtask

    task automatic test_backpressure();
        set_view(int'($urandom_range(0, 4095)) - 2048, 40, 40);
        gaps_on  = 1'b0;
        hold_req = 1'b1;
        while (!hold_active) @(posedge clk);
        repeat (4) send_batch(6, 100);
        wait_for_results();
        gaps_on = 1'b1;
    endtask

    task automatic test_random_batches();
        int start;
        int phase;
        int n;
        start = items_sent;
        phase = 0;
        while (items_sent - start < 180) begin
            case (phase % 4)
                0: set_view($urandom_range(0, 65535), $urandom_range(0, 65535),
                            $urandom_range(0, 255));
                1: set_view($urandom_range(0, 65535), $urandom_range(0, 65535), 255);
                2: set_view($urandom_range(0, 65535), $urandom_range(0, 65535),
                            $urandom_range(0, 12));
                default: set_view($urandom_range(0, 1) ? 32767 : -32768,
                                  $urandom_range(0, 1) ? 32767 : -32768,
                                  $urandom_range(0, 255));
            endcase
            gaps_on = (phase % 3 != 2);
            repeat ($urandom_range(3, 6)) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                : $urandom_range(1, 10);
                send_batch(n, 85);
            end
            wait_for_results();
            phase++;
        end
        gaps_on = 1'b1;
    endtask

    // ---------------------------------------------------------------- main

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_default_radius();
        test_center_extremes();
        test_center_truncation();
        test_capacity();
        test_backpressure();
        test_random_batches();

        wait_for_results();
        repeat (TAIL) @(posedge clk);
        if (expected_words.size() != 0) begin
            errors += expected_words.size();
            $display("%0t: %0d result words never arrived", $time, expected_words.size());
        end

        $display("Sent %0d cell words in %0d batches (%0d over capacity, %0d with none kept)",
                 items_sent, batches, overflow_batches, empty_batches);
        $display("Checked %0d sorted words across %0d register writes incl. extreme views",
                 words_checked, reg_writes);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
